// ===== rtl/dfs_pkg.sv =====
// ----------------------------------------------------------------------------
// dfs_pkg
// Types and constants shared by the delimited field splitter and its
// result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_pkg;

  typedef enum logic {
    KIND_FIELD   = 1'b0,
    KIND_SUMMARY = 1'b1
  } rec_kind_e;

  typedef enum logic [1:0] {
    CLASS_DATA    = 2'd0,
    CLASS_EMPTY   = 2'd1,
    CLASS_COMMENT = 2'd2
  } line_class_e;

  // configuration register indexes
  localparam logic [1:0] CFG_DELIMITER = 2'd0;
  localparam logic [1:0] CFG_COMMENT   = 2'd1;
  localparam logic [1:0] CFG_LIMIT     = 2'd2;

  localparam logic [7:0] DELIMITER_RESET = 8'd44;
  localparam logic [7:0] COMMENT_RESET   = 8'd35;
  localparam logic [5:0] LIMIT_RESET     = 6'd32;
  localparam int unsigned LIMIT_CAP      = 32;

  typedef struct packed {
    rec_kind_e   kind;
    logic [4:0]  field_number;
    logic [7:0]  field_offset;
    logic [8:0]  field_size;
    logic [5:0]  line_field_count;
    logic [15:0] line_index;
    line_class_e line_class;
    logic        line_overflow;
    logic        run_last;
  } rec_t;

endpackage

`default_nettype wire

// ===== rtl/dfs_rec_queue.sv =====
// ----------------------------------------------------------------------------
// dfs_rec_queue
// Three-entry result queue: takes up to two records per cycle, gives one
// record per beat from its head.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_rec_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_a_i,
  input  wire dfs_pkg::rec_t rec_a_i,
  input  wire logic          push_b_i,
  input  wire dfs_pkg::rec_t rec_b_i,
  input  wire logic          pop_i,
  output dfs_pkg::rec_t      head_o,
  output logic [1:0]         count_o
);

  localparam int unsigned Depth = 3;

  dfs_pkg::rec_t slots_q [Depth];
  dfs_pkg::rec_t slots_d [Depth];
  logic [1:0]    count_q, count_d;
  logic [1:0]    keep;
  logic [1:0]    idx_a, idx_b;

  always_comb begin
    keep  = count_q - {1'b0, pop_i};
    idx_a = keep;
    idx_b = keep + {1'b0, push_a_i};
    for (int i = 0; i < Depth; i++) begin
      if (pop_i && i < Depth - 1) begin
        slots_d[i] = slots_q[i + 1];
      end else begin
        slots_d[i] = slots_q[i];
      end
    end
    if (push_a_i) begin
      slots_d[idx_a] = rec_a_i;
    end
    if (push_b_i) begin
      slots_d[idx_b] = rec_b_i;
    end
    count_d = keep + {1'b0, push_a_i} + {1'b0, push_b_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      slots_q[i] <= slots_d[i];
    end
  end

  assign head_o  = slots_q[0];
  assign count_o = count_q;

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3 || !(push_a_i || push_b_i))
    else $error("queue pushed while full");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_a_i || push_b_i) |-> (count_q <= 2'd1))
    else $error("push without room for two records");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && count_q == 2'd1 && !push_a_i && !push_b_i) |=> (count_q == 2'd0))
    else $error("queue did not drain");

  a_pop_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != 2'd0))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/delimited_field_splitter.sv =====
// ----------------------------------------------------------------------------
// delimited_field_splitter
// Splits byte-serial text lines into fields at a configurable delimiter and
// gives a field record per field up to the field limit (none on comment lines) plus a summary record per line.
// ----------------------------------------------------------------------------
// a record enters the result queue when its byte is taken and is offered once it reaches the queue head
// throughput: one byte per cycle while each byte gives at most one record and the receiver does not stall;
//   a byte giving a field and a summary needs two output beats
// the byte is taken when the three-entry result queue holds at most one record
// reset clears line state, line counter, queue and sets config to defaults
`default_nettype none

module delimited_field_splitter #(
  parameter int unsigned MAX_LINE   = 256,
  parameter int unsigned MAX_FIELDS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input bytes
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        line_end_i,
  input  wire logic        file_restart_i,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  // result records
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             record_kind_o,
  output logic [4:0]       field_number_o,
  output logic [7:0]       field_offset_o,
  output logic [8:0]       field_size_o,
  output logic [5:0]       line_field_count_o,
  output logic [15:0]      line_index_o,
  output logic [1:0]       line_class_o,
  output logic             line_overflow_o,
  output logic             run_last_o
);

  localparam int unsigned PosW = $clog2(MAX_LINE + 1);
  localparam int unsigned Cap  = (MAX_FIELDS < dfs_pkg::LIMIT_CAP) ?
                                 MAX_FIELDS : dfs_pkg::LIMIT_CAP;

  // configuration
  logic [7:0] delim_q, comment_q;
  logic [5:0] limit_q;

  // line state
  logic [PosW-1:0] pos_q, pos_d;
  logic [5:0]      found_q, found_d;
  logic [PosW-1:0] start_q, start_d;
  logic [PosW-1:0] nsend_q, nsend_d;
  logic            nonsp_q, nonsp_d;
  logic            cmt_q, cmt_d;
  logic [15:0]     line_q, line_d;
  logic            ovf_q, ovf_d;

  logic            accept;
  logic            pop;
  logic [1:0]      q_count;
  logic [5:0]      lim;
  logic            is_ws;
  logic            field_v;
  logic [4:0]      field_num;
  logic [PosW-1:0] field_start;
  logic [PosW-1:0] field_len;
  dfs_pkg::rec_t   field_rec, summ_rec, head;
  dfs_pkg::line_class_e cls;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (q_count > 2'd1);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    lim = limit_q;
    if (lim == 6'd0) begin
      lim = 6'd1;
    end
    if (lim > 6'(Cap)) begin
      lim = 6'(Cap);
    end
    is_ws = text_byte_i inside {8'd32, [8'd9:8'd13]};
  end

  always_comb begin
    pos_d       = pos_q;
    found_d     = found_q;
    start_d     = start_q;
    nsend_d     = nsend_q;
    nonsp_d     = nonsp_q;
    cmt_d       = cmt_q;
    line_d      = line_q;
    ovf_d       = ovf_q;
    field_v     = 1'b0;
    field_num   = '0;
    field_start = '0;
    field_len   = '0;
    cls         = dfs_pkg::CLASS_DATA;

    if (file_restart_i) begin
      pos_d   = '0;
      found_d = '0;
      start_d = '0;
      nsend_d = '0;
      nonsp_d = 1'b0;
      cmt_d   = 1'b0;
      ovf_d   = 1'b0;
      line_d  = '0;
    end
    if (pos_d == '0) begin
      cmt_d = (text_byte_i == comment_q);
    end

    if (32'(pos_d) >= 32'(MAX_LINE)) begin
      ovf_d = 1'b1;
    end else begin
      if (found_d < lim) begin
        if (text_byte_i == delim_q) begin
          field_v     = !cmt_d;
          field_num   = found_d[4:0];
          field_start = start_d;
          field_len   = pos_d - start_d;
          found_d     = found_d + 6'd1;
          start_d     = pos_d + 1'b1;
          nsend_d     = pos_d + 1'b1;
          nonsp_d     = 1'b0;
        end else if (!is_ws) begin
          nonsp_d = 1'b1;
          nsend_d = pos_d + 1'b1;
        end
      end
      pos_d = pos_d + 1'b1;
    end

    if (line_end_i) begin
      // trailing field: only when it holds something other than whitespace
      if (found_d < lim && nonsp_d) begin
        field_v     = !cmt_d;
        field_num   = found_d[4:0];
        field_start = start_d;
        field_len   = nsend_d - start_d;
        found_d     = found_d + 6'd1;
      end
      if (line_d != 16'hFFFF) begin
        line_d = line_d + 16'd1;
      end
      if (found_d == 6'd0) begin
        cls = dfs_pkg::CLASS_EMPTY;
      end else if (cmt_d) begin
        cls = dfs_pkg::CLASS_COMMENT;
      end else begin
        cls = dfs_pkg::CLASS_DATA;
      end
    end
  end

  always_comb begin
    field_rec                  = '0;
    field_rec.kind             = dfs_pkg::KIND_FIELD;
    field_rec.field_number     = field_num;
    field_rec.field_offset     = (32'(field_start) > 32'd255) ? 8'hFF : 8'(field_start);
    field_rec.field_size       = (32'(field_len) > 32'd511) ? 9'h1FF : 9'(field_len);
    field_rec.line_class       = dfs_pkg::CLASS_DATA;
    field_rec.run_last         = !line_end_i;

    summ_rec                   = '0;
    summ_rec.kind              = dfs_pkg::KIND_SUMMARY;
    summ_rec.line_field_count  = (cls == dfs_pkg::CLASS_DATA) ? found_d : 6'd0;
    summ_rec.line_index        = line_d;
    summ_rec.line_class        = cls;
    summ_rec.line_overflow     = ovf_d;
    summ_rec.run_last          = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q   <= dfs_pkg::DELIMITER_RESET;
      comment_q <= dfs_pkg::COMMENT_RESET;
      limit_q   <= dfs_pkg::LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        dfs_pkg::CFG_DELIMITER: delim_q   <= cfg_data_i;
        dfs_pkg::CFG_COMMENT:   comment_q <= cfg_data_i;
        dfs_pkg::CFG_LIMIT:     limit_q   <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      found_q <= '0;
      start_q <= '0;
      nsend_q <= '0;
      nonsp_q <= 1'b0;
      cmt_q   <= 1'b0;
      line_q  <= '0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      line_q <= line_d;
      if (line_end_i) begin
        pos_q   <= '0;
        found_q <= '0;
        start_q <= '0;
        nsend_q <= '0;
        nonsp_q <= 1'b0;
        cmt_q   <= 1'b0;
        ovf_q   <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        found_q <= found_d;
        start_q <= start_d;
        nsend_q <= nsend_d;
        nonsp_q <= nonsp_d;
        cmt_q   <= cmt_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  assign pop = out_valid_o && !out_stall_i;

  dfs_rec_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_a_i (accept && field_v),
    .rec_a_i  (field_rec),
    .push_b_i (accept && line_end_i),
    .rec_b_i  (summ_rec),
    .pop_i    (pop),
    .head_o   (head),
    .count_o  (q_count)
  );

  assign out_valid_o        = (q_count != 2'd0);
  assign record_kind_o      = head.kind;
  assign field_number_o     = head.field_number;
  assign field_offset_o     = head.field_offset;
  assign field_size_o       = head.field_size;
  assign line_field_count_o = head.line_field_count;
  assign line_index_o       = head.line_index;
  assign line_class_o       = head.line_class;
  assign line_overflow_o    = head.line_overflow;
  assign run_last_o         = head.run_last;

  a_line_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && line_end_i) |=> (pos_q == '0 && found_q == 6'd0))
    else $error("line state not cleared after line end");

  a_found_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q <= 6'(Cap))
    else $error("field count beyond limit");

  a_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) <= 32'(MAX_LINE))
    else $error("byte position beyond line length");

  a_start_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_q <= nsend_q) && (nsend_q <= pos_q))
    else $error("field start and end out of order");

endmodule

`default_nettype wire

// ===== bench/delimited_field_splitter_tb.sv =====
// ----------------------------------------------------------------------------
// delimited_field_splitter_tb
// Self-checking bench for the field splitter. Text beats are pushed through
// an in-house line predictor that queues the field and summary records each
// byte should give; every record beat from the block is compared field by
// field with the oldest queued record. A short directed table runs first,
// then phases of random lines under several delimiter, comment and limit
// settings and idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module delimited_field_splitter_tb;

  localparam int unsigned MAX_LINE     = 256;
  localparam int unsigned MAX_FIELDS   = 32;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_BYTES  = 130;
  localparam int unsigned DIR_ROWS     = 26;
  // index outside the register map, written to show it has no effect
  localparam logic [1:0]  CFG_UNMAPPED = 2'd3;

  typedef struct {
    logic [7:0]    text;
    logic          last;
    logic          restart;
    int unsigned   reps;
    logic          typed;
    dfs_pkg::rec_t want;
  } dir_row_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [7:0]  text_byte_i    = 8'd0;
  logic        line_end_i     = 1'b0;
  logic        file_restart_i = 1'b0;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i    = dfs_pkg::CFG_DELIMITER;
  logic [7:0]  cfg_data_i     = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic        record_kind_o;
  logic [4:0]  field_number_o;
  logic [7:0]  field_offset_o;
  logic [8:0]  field_size_o;
  logic [5:0]  line_field_count_o;
  logic [15:0] line_index_o;
  logic [1:0]  line_class_o;
  logic        line_overflow_o;
  logic        run_last_o;

  delimited_field_splitter #(
    .MAX_LINE  (MAX_LINE),
    .MAX_FIELDS(MAX_FIELDS)
  ) dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor copy of the registers and the line state
  logic [7:0]  delim_cfg   = dfs_pkg::DELIMITER_RESET;
  logic [7:0]  comment_cfg = dfs_pkg::COMMENT_RESET;
  logic [5:0]  limit_cfg   = dfs_pkg::LIMIT_RESET;
  logic [8:0]  line_pos    = '0;
  logic [5:0]  fields_taken = '0;
  logic [8:0]  field_start = '0;
  logic [8:0]  nonspace_end = '0;
  logic        seen_nonspace = 1'b0;
  logic        in_comment  = 1'b0;
  logic        overflowed  = 1'b0;
  logic [15:0] line_ctr    = '0;

  dfs_pkg::rec_t records_due[$];
  int unsigned mismatch_cnt   = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  function automatic logic is_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [5:0] active_limit();
    logic [5:0] lim;
    lim = limit_cfg;
    if (lim == 6'd0) lim = 6'd1;
    if (lim > dfs_pkg::LIMIT_CAP) lim = 6'(dfs_pkg::LIMIT_CAP);
    if (lim > MAX_FIELDS) lim = 6'(MAX_FIELDS);
    return lim;
  endfunction

  function automatic void clear_line();
    line_pos      = '0;
    fields_taken  = '0;
    field_start   = '0;
    nonspace_end  = '0;
    seen_nonspace = 1'b0;
    in_comment    = 1'b0;
    overflowed    = 1'b0;
  endfunction

  function automatic dfs_pkg::rec_t summ(logic [5:0] cnt, logic [15:0] idx,
                                         dfs_pkg::line_class_e cls, logic ovf);
    dfs_pkg::rec_t r;
    r = '0;
    r.kind             = dfs_pkg::KIND_SUMMARY;
    r.line_field_count = cnt;
    r.line_index       = idx;
    r.line_class       = cls;
    r.line_overflow    = ovf;
    r.run_last         = 1'b1;
    return r;
  endfunction

  function automatic void push_field(logic [5:0] num, logic [8:0] start, logic [8:0] size);
    dfs_pkg::rec_t r;
    r = '0;
    r.kind         = dfs_pkg::KIND_FIELD;
    r.field_number = num[4:0];
    r.field_offset = (start > 9'd255) ? 8'hFF : start[7:0];
    r.field_size   = size;
    r.line_class   = dfs_pkg::CLASS_DATA;
    records_due.push_back(r);
  endfunction

  // advances the line state by one text byte and queues the records it gives
  function automatic void split_byte(logic [7:0] b, logic last, logic restart);
    logic [5:0]           lim;
    logic [8:0]           p;
    dfs_pkg::line_class_e cls;
    dfs_pkg::rec_t        tail;
    int unsigned          n0;
    lim = active_limit();
    n0  = records_due.size();
    if (restart) begin
      clear_line();
      line_ctr = '0;
    end
    p = line_pos;
    if (p == 9'd0) in_comment = (b == comment_cfg);
    if (p >= MAX_LINE) begin
      overflowed = 1'b1;
    end else begin
      if (fields_taken < lim) begin
        if (b == delim_cfg) begin
          if (!in_comment) push_field(fields_taken, field_start, p - field_start);
          fields_taken++;
          field_start   = p + 9'd1;
          nonspace_end  = p + 9'd1;
          seen_nonspace = 1'b0;
        end else if (!is_space(b)) begin
          seen_nonspace = 1'b1;
          nonspace_end  = p + 9'd1;
        end
      end
      line_pos = p + 9'd1;
    end
    if (last) begin
      // unclosed final field: kept only if it holds something besides blanks
      if (fields_taken < lim && seen_nonspace) begin
        if (!in_comment) push_field(fields_taken, field_start, nonspace_end - field_start);
        fields_taken++;
      end
      if (line_ctr != 16'hFFFF) line_ctr++;
      if (fields_taken == 6'd0) cls = dfs_pkg::CLASS_EMPTY;
      else if (in_comment) cls = dfs_pkg::CLASS_COMMENT;
      else cls = dfs_pkg::CLASS_DATA;
      records_due.push_back(summ((cls == dfs_pkg::CLASS_DATA) ? fields_taken : 6'd0,
                                 line_ctr, cls, overflowed));
      clear_line();
    end
    if (records_due.size() > n0) begin
      tail = records_due.pop_back();
      tail.run_last = 1'b1;
      records_due.push_back(tail);
    end
  endfunction

  function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // record beats are checked and the receiver stall is chosen here
  always @(posedge clk_i) begin : record_monitor
    dfs_pkg::rec_t want;
    if (out_valid_o && !out_stall_i) begin
      if (records_due.size() == 0) begin
        $error("record beat with nothing expected: kind %0d", record_kind_o);
        mismatch_cnt++;
      end else begin
        want = records_due.pop_front();
        cmp_field("record_kind", 16'(want.kind), 16'(record_kind_o));
        cmp_field("field_number", 16'(want.field_number), 16'(field_number_o));
        cmp_field("field_offset", 16'(want.field_offset), 16'(field_offset_o));
        cmp_field("field_size", 16'(want.field_size), 16'(field_size_o));
        cmp_field("line_field_count", 16'(want.line_field_count), 16'(line_field_count_o));
        cmp_field("line_index", want.line_index, line_index_o);
        cmp_field("line_class", 16'(want.line_class), 16'(line_class_o));
        cmp_field("line_overflow", 16'(want.line_overflow), 16'(line_overflow_o));
        cmp_field("run_last", 16'(want.run_last), 16'(run_last_o));
      end
    end
    out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic last, logic restart, logic typed,
                           dfs_pkg::rec_t want);
    int unsigned n0;
    in_valid_i     <= 1'b1;
    text_byte_i    <= b;
    line_end_i     <= last;
    file_restart_i <= restart;
    do @(posedge clk_i); while (in_stall_o);
    n0 = records_due.size();
    split_byte(b, last, restart);
    if (typed) begin
      while (records_due.size() > n0) void'(records_due.pop_back());
      records_due.push_back(want);
    end
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (records_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [7:0] delim, logic [7:0] cmt, logic [5:0] lim);
    logic [1:0] idx [4];
    logic [7:0] val [4];
    idx = '{dfs_pkg::CFG_DELIMITER, dfs_pkg::CFG_COMMENT, dfs_pkg::CFG_LIMIT, CFG_UNMAPPED};
    val = '{delim, cmt, {2'b00, lim}, 8'($urandom_range(255))};
    foreach (idx[k]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[k])
        dfs_pkg::CFG_DELIMITER: delim_cfg = val[k];
        dfs_pkg::CFG_COMMENT:   comment_cfg = val[k];
        dfs_pkg::CFG_LIMIT:     limit_cfg = val[k][5:0];
        default:                ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_text(logic first, logic noise);
    logic [7:0]  blanks [6];
    int unsigned r;
    blanks = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
    r = $urandom_range(99);
    if (noise) return 8'($urandom_range(255));
    if (first && r < 12) return comment_cfg;
    if (r < 30) return delim_cfg;
    if (r < 50) return blanks[$urandom_range(5)];
    if (r < 53) return comment_cfg;
    return 8'($urandom_range(255));
  endfunction

  // one random line; returns the number of bytes inside the line length
  task automatic send_random_line(output int unsigned taken);
    int unsigned len;
    int unsigned r;
    logic        noise;
    r     = $urandom_range(199);
    noise = ($urandom_range(99) < 8);
    if (r == 0) len = MAX_LINE + $urandom_range(1, 20);
    else if (r < 20) len = $urandom_range(13, 40);
    else len = $urandom_range(1, 12);
    taken = 0;
    for (int i = 0; i < len; i++) begin
      send_byte(pick_text(i == 0, noise), i == len - 1, $urandom_range(99) < 3, 1'b0, '0);
      if (i < MAX_LINE) taken++;
    end
  endtask

  task automatic set_idle(int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
      default: begin send_idle_pct = 9; recv_stall_pct = 9; end
    endcase
  endtask

  initial begin
    dir_row_t    dir_rows [DIR_ROWS];
    logic [7:0]  delim_set [PHASES];
    logic [7:0]  comment_set [PHASES];
    logic [5:0]  limit_set [PHASES];
    int unsigned phase_bytes;
    int unsigned taken;

    dir_rows = '{
      // first lines after reset: comment-only and blank
      '{8'h23, 1'b1, 1'b0, 1, 1'b1, summ(6'd0, 16'd1, dfs_pkg::CLASS_COMMENT, 1'b0)},
      '{8'h20, 1'b1, 1'b0, 1, 1'b1, summ(6'd0, 16'd2, dfs_pkg::CLASS_EMPTY, 1'b0)},
      // long line: a full-width field, then bytes past the end
      '{8'h78, 1'b0, 1'b0, 257, 1'b0, '0},
      '{8'h20, 1'b1, 1'b0, 1, 1'b0, '0},
      // blank fields between delimiters, trailing blanks trimmed
      '{8'h61, 1'b0, 1'b0, 1, 1'b0, '0},
      '{8'h2C, 1'b0, 1'b0, 2, 1'b0, '0},
      '{8'h62, 1'b0, 1'b0, 1, 1'b0, '0},
      '{8'h20, 1'b0, 1'b0, 1, 1'b0, '0},
      '{8'h0D, 1'b1, 1'b0, 1, 1'b0, '0},
      '{8'h2C, 1'b1, 1'b0, 1, 1'b0, '0},
      // restart in the middle of a line
      '{8'h78, 1'b0, 1'b0, 1, 1'b0, '0},
      '{8'h2C, 1'b0, 1'b1, 1, 1'b0, '0},
      '{8'h79, 1'b1, 1'b0, 1, 1'b0, '0},
      // byte extremes and the edges of the blank range
      '{8'hFF, 1'b0, 1'b0, 1, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, 1, 1'b0, '0},
      '{8'h08, 1'b0, 1'b0, 1, 1'b0, '0},
      '{8'h0E, 1'b0, 1'b0, 1, 1'b0, '0},
      '{8'h0B, 1'b0, 1'b0, 1, 1'b0, '0},
      '{8'h0C, 1'b0, 1'b0, 1, 1'b0, '0},
      '{8'h0A, 1'b1, 1'b0, 1, 1'b0, '0},
      // more delimiters than the field limit
      '{8'h2C, 1'b0, 1'b0, 34, 1'b0, '0},
      '{8'h71, 1'b1, 1'b0, 1, 1'b0, '0},
      // comment line that would have fields
      '{8'h23, 1'b0, 1'b0, 1, 1'b0, '0},
      '{8'h2C, 1'b0, 1'b0, 1, 1'b0, '0},
      '{8'h61, 1'b1, 1'b0, 1, 1'b0, '0},
      // restart and line end on one byte
      '{8'h7A, 1'b1, 1'b1, 1, 1'b0, '0}
    };
    delim_set   = '{8'd44, 8'd0,   8'd255, 8'd9,  8'd32, 8'd59, 8'd0, 8'd44};
    comment_set = '{8'd35, 8'd255, 8'd0,   8'd44, 8'd59, 8'd59, 8'd0, 8'd32};
    limit_set   = '{6'd32, 6'd1,   6'd3,   6'd0,  6'd32, 6'd40, 6'd0, 6'd2};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        send_byte(dir_rows[r].text, dir_rows[r].last && k == dir_rows[r].reps - 1,
                  dir_rows[r].restart && k == 0, dir_rows[r].typed, dir_rows[r].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // registers change only with nothing in flight
      wait_idle();
      if (ph == 6) begin
        program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                     6'($urandom_range(1, 32)));
      end else begin
        program_regs(delim_set[ph], comment_set[ph], limit_set[ph]);
      end
      set_idle(ph % 4);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        send_random_line(taken);
        phase_bytes += taken;
      end
    end

    wait_idle();
    if (mismatch_cnt == 0 && records_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dfs_pkg.sv
rtl/dfs_rec_queue.sv
rtl/delimited_field_splitter.sv
bench/delimited_field_splitter_tb.sv
